// ===== hw/rtl/pfba_pkg.sv =====
`timescale 1ns / 1ps
package pfba_pkg;

	localparam int PAGE_COUNT = 32768;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS = 32;
	localparam int WORD_COUNT = PAGE_COUNT / WORD_BITS;
	localparam int IDX_W = $clog2(PAGE_COUNT);
	localparam int HINT_W = IDX_W + 1;
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int WADDR_W = $clog2(WORD_COUNT);
	localparam int ADDR_W = 32;
	localparam int RESERVED_W = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_MEMORY_BASE = 1'b0;
	localparam logic REG_RESERVED_COUNT = 1'b1;
	localparam logic [ADDR_W-1:0] MEMORY_BASE_RESET = 32'h0010_0000;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_REINIT = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_OOM = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [ADDR_W-1:0] page_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted_address;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic found;
		logic [BIT_W-1:0] pos;
	} zfind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_EV,
		S_FREE_RD,
		S_FREE_WR,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/pfba_ram.sv =====
`timescale 1ns / 1ps
module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/pfba_zero_find.sv =====
`timescale 1ns / 1ps
module pfba_zero_find (
	input  logic [pfba_pkg::WORD_BITS-1:0] word,
	input  logic [pfba_pkg::BIT_W-1:0]     start,
	output pfba_pkg::zfind_t               res
);

	// lowest clear bit at or above start
	always_comb begin
		res = '0;
		for (int i = pfba_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i] && (pfba_pkg::BIT_W'(i) >= start)) begin
				res.found = 1'b1;
				res.pos = pfba_pkg::BIT_W'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/page_frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// Bitmap page allocator over 32768 pages, one used bit per page, held 32 pages to a
// word in a single RAM. Allocate reads the word holding the lowest-free hint and each
// word after it, each read and then searched for a clear bit; a hint at the top of
// the map reports out of pages without a read. Free is a read-modify-write of one
// word; a free that is ignored and an unused operation code answer without touching
// the map. Reinitialize sweeps every word of the map, one per cycle, writing the
// reserved pattern. After reset the same sweep clears the map before the first
// request transfer; register writes are taken throughout. One request is in flight
// at a time; a finished result waits in the output register while the next request
// is taken.
module page_frame_bitmap_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  pfba_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output pfba_pkg::rsp_t                  rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pfba_pkg::PADDR_W-1:0]    paddr,
	input  logic [pfba_pkg::PDATA_W-1:0]    pwdata,
	output logic [pfba_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);

	pfba_pkg::state_t state_q, state_d;
	logic [pfba_pkg::HINT_W-1:0] hint_q;
	logic [pfba_pkg::HINT_W-1:0] fill_q;
	logic [pfba_pkg::WADDR_W-1:0] word_q;
	logic [pfba_pkg::BIT_W-1:0] bit_q;
	logic reply_q;
	logic [pfba_pkg::ADDR_W-1:0] base_q;
	logic [pfba_pkg::RESERVED_W-1:0] rsvd_q;
	pfba_pkg::rsp_t res_q;
	pfba_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic ram_we, ram_re;
	logic [pfba_pkg::WADDR_W-1:0] ram_waddr, ram_raddr;
	logic [pfba_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata;
	logic [pfba_pkg::WORD_BITS-1:0] fill_word;
	pfba_pkg::zfind_t zf;

	logic req_xfer, rsp_load, last_word;
	logic [pfba_pkg::ADDR_W-1:0] diff;
	logic free_bad;
	logic [pfba_pkg::IDX_W-1:0] free_idx;
	logic [pfba_pkg::HINT_W-1:0] sat_n;
	logic [pfba_pkg::IDX_W-1:0] found_idx;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == pfba_pkg::REG_RESERVED_COUNT) ?
		pfba_pkg::PDATA_W'(rsvd_q) : base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= pfba_pkg::MEMORY_BASE_RESET;
			rsvd_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == pfba_pkg::REG_RESERVED_COUNT) begin
				rsvd_q <= pwdata[pfba_pkg::RESERVED_W-1:0];
			end else begin
				base_q <= pwdata;
			end
		end
	end

	assign req_ready = (state_q == pfba_pkg::S_IDLE);
	assign req_xfer = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign rsp_load = (state_q == pfba_pkg::S_DONE) && (!rsp_valid_q || rsp_ready);
	assign last_word = (word_q == pfba_pkg::WADDR_W'(pfba_pkg::WORD_COUNT - 1));

	assign diff = req.page_address - base_q;
	assign free_bad = (req.page_address == '0) || (req.page_address < base_q) ||
		((diff >> (pfba_pkg::PAGE_SHIFT + pfba_pkg::IDX_W)) != '0);
	assign free_idx = diff[pfba_pkg::PAGE_SHIFT +: pfba_pkg::IDX_W];
	assign sat_n = (32'(rsvd_q) > pfba_pkg::PAGE_COUNT) ?
		pfba_pkg::HINT_W'(pfba_pkg::PAGE_COUNT) : pfba_pkg::HINT_W'(rsvd_q);
	assign found_idx = {word_q, zf.pos};

	always_comb begin
		if (fill_q[pfba_pkg::IDX_W]) begin
			fill_word = '1;
		end else if (word_q < fill_q[pfba_pkg::IDX_W-1:pfba_pkg::BIT_W]) begin
			fill_word = '1;
		end else if (word_q == fill_q[pfba_pkg::IDX_W-1:pfba_pkg::BIT_W]) begin
			fill_word = ~({pfba_pkg::WORD_BITS{1'b1}} << fill_q[pfba_pkg::BIT_W-1:0]);
		end else begin
			fill_word = '0;
		end
	end

	pfba_zero_find u_zero_find (
		.word  (ram_rdata),
		.start (bit_q),
		.res   (zf)
	);

	pfba_ram #(
		.WIDTH (pfba_pkg::WORD_BITS),
		.DEPTH (pfba_pkg::WORD_COUNT)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = word_q;
		ram_raddr = word_q;
		ram_wdata = fill_word;
		unique case (state_q)
			pfba_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				if (last_word) begin
					state_d = reply_q ? pfba_pkg::S_DONE : pfba_pkg::S_IDLE;
				end
			end
			pfba_pkg::S_IDLE: begin
				if (req_xfer) begin
					unique case (req.operation)
						pfba_pkg::OP_ALLOC: begin
							state_d = hint_q[pfba_pkg::IDX_W] ?
								pfba_pkg::S_DONE : pfba_pkg::S_ALLOC_RD;
						end
						pfba_pkg::OP_FREE: begin
							state_d = free_bad ? pfba_pkg::S_DONE : pfba_pkg::S_FREE_RD;
						end
						pfba_pkg::OP_REINIT: state_d = pfba_pkg::S_CLEAR;
						default: state_d = pfba_pkg::S_DONE;
					endcase
				end
			end
			pfba_pkg::S_ALLOC_RD: begin
				ram_re = 1'b1;
				state_d = pfba_pkg::S_ALLOC_EV;
			end
			pfba_pkg::S_ALLOC_EV: begin
				if (zf.found) begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata | (pfba_pkg::WORD_BITS'(1) << zf.pos);
					state_d = pfba_pkg::S_DONE;
				end else if (last_word) begin
					state_d = pfba_pkg::S_DONE;
				end else begin
					state_d = pfba_pkg::S_ALLOC_RD;
				end
			end
			pfba_pkg::S_FREE_RD: begin
				ram_re = 1'b1;
				state_d = pfba_pkg::S_FREE_WR;
			end
			pfba_pkg::S_FREE_WR: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata & ~(pfba_pkg::WORD_BITS'(1) << bit_q);
				state_d = pfba_pkg::S_DONE;
			end
			pfba_pkg::S_DONE: begin
				if (rsp_load) begin
					state_d = pfba_pkg::S_IDLE;
				end
			end
			default: state_d = pfba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
			fill_q <= '0;
			word_q <= '0;
			bit_q <= '0;
			reply_q <= 1'b0;
		end else begin
			unique case (state_q)
				pfba_pkg::S_CLEAR: begin
					word_q <= word_q + pfba_pkg::WADDR_W'(1);
					if (last_word) begin
						hint_q <= fill_q;
					end
				end
				pfba_pkg::S_IDLE: begin
					if (req_xfer) begin
						if (req.operation == pfba_pkg::OP_ALLOC) begin
							word_q <= hint_q[pfba_pkg::IDX_W-1:pfba_pkg::BIT_W];
							bit_q <= hint_q[pfba_pkg::BIT_W-1:0];
						end else if (req.operation == pfba_pkg::OP_FREE) begin
							word_q <= free_idx[pfba_pkg::IDX_W-1:pfba_pkg::BIT_W];
							bit_q <= free_idx[pfba_pkg::BIT_W-1:0];
						end else if (req.operation == pfba_pkg::OP_REINIT) begin
							word_q <= '0;
							fill_q <= sat_n;
							reply_q <= 1'b1;
						end
					end
				end
				pfba_pkg::S_ALLOC_EV: begin
					if (zf.found) begin
						hint_q <= pfba_pkg::HINT_W'(found_idx) + pfba_pkg::HINT_W'(1);
					end else begin
						word_q <= word_q + pfba_pkg::WADDR_W'(1);
						bit_q <= '0;
					end
				end
				pfba_pkg::S_FREE_WR: begin
					if ({1'b0, word_q, bit_q} < hint_q) begin
						hint_q <= {1'b0, word_q, bit_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pfba_pkg::S_IDLE: begin
				res_q.granted_address <= '0;
				res_q.status <= pfba_pkg::ST_DONE;
				if (req.operation == pfba_pkg::OP_ALLOC && hint_q[pfba_pkg::IDX_W]) begin
					res_q.status <= pfba_pkg::ST_OOM;
				end else if (req.operation == pfba_pkg::OP_FREE && free_bad) begin
					res_q.status <= pfba_pkg::ST_IGNORED;
				end
			end
			pfba_pkg::S_ALLOC_EV: begin
				if (zf.found) begin
					res_q.granted_address <= base_q +
						(pfba_pkg::ADDR_W'(found_idx) << pfba_pkg::PAGE_SHIFT);
				end else if (last_word) begin
					res_q.status <= pfba_pkg::ST_OOM;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= pfba_pkg::HINT_W'(pfba_pkg::PAGE_COUNT))
		else $error("hint beyond last page");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != pfba_pkg::ST_DONE |-> rsp.granted_address == '0)
		else $error("grant address on failed transfer");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfba_pkg::S_IDLE || state_q == pfba_pkg::S_DONE) |-> !ram_we)
		else $error("map written outside an operation");

	a_alloc_hint: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfba_pkg::S_ALLOC_EV && zf.found |=>
		hint_q == pfba_pkg::HINT_W'($past(found_idx)) + pfba_pkg::HINT_W'(1))
		else $error("hint not advanced past grant");

endmodule
